>>> rtl/rfud_pkg.sv
package rfud_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 152;
    localparam int CFG_DATA_W  = 15;

    localparam logic [14:0] CLAMP_LIMIT_RST = 15'd32112;
    localparam logic [14:0] DECAY_GAIN_RST  = 15'd32276;

    localparam logic CFG_CLAMP_LIMIT = 1'b0;
    localparam logic CFG_DECAY_GAIN  = 1'b1;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_DROP  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DECAY
    } t_state;

    typedef struct packed {
        logic load;
        logic mult;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic underrun_tick;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/rfud_ram.sv
module rfud_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rfud_ctrl.sv
module rfud_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    output rfud_pkg::t_dp_cmd o_cmd,
    input  rfud_pkg::t_dp_sts i_sts
);
    import rfud_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.underrun_tick) begin
                    n_state = S_DECAY;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DECAY: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready    = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_EXEC: begin
                o_cmd.mult   = i_sts.underrun_tick;
                o_cmd.commit = !i_sts.underrun_tick && i_sts.out_free;
            end
            S_DECAY: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("load did not enter execute");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while output register busy");
    a_mult_to_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mult |=> r_state == S_DECAY)
        else $error("multiply did not enter decay");

endmodule

>>> rtl/rfud_dp.sv
module rfud_dp #(
    parameter int DEPTH = rfud_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rfud_pkg::t_dp_cmd                i_cmd,
    output rfud_pkg::t_dp_sts                o_sts,
    input  logic [rfud_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic [rfud_pkg::IN_TUSER_W-1:0]  i_in_tuser,
    input  logic                             i_in_tlast,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [rfud_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_tvalid,
    input  logic                             i_out_tready,
    output logic [rfud_pkg::OUT_TDATA_W-1:0] o_out_tdata
);
    import rfud_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW > 10) ? AW : 10;
    localparam logic [AW:0]   DEPTH_V  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] FILL_MAX = AW'(DEPTH - 1);

    logic [1:0]         r_mode;
    logic [15:0]        r_sample;
    logic [9:0]         r_dcnt;
    logic               r_last;

    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_fill;
    logic [15:0]        r_held;
    logic               r_brej;
    logic               r_bund;
    logic [31:0]        r_ovf;
    logic [31:0]        r_und;
    logic [47:0]        r_frames;
    logic [14:0]        r_clamp;
    logic [14:0]        r_gain;
    logic [30:0]        r_prod;
    logic               r_neg;

    logic               r_m_valid;
    logic [15:0]        r_o_sample;
    logic               r_o_wacc;
    logic               r_o_under;
    logic [9:0]         r_o_drop;

    logic               is_write;
    logic               is_tick;
    logic               is_drop;
    logic               full;
    logic               empty;
    logic               out_free;
    logic [AW:0]        sum_wr;
    logic [AW:0]        sum_inc;
    logic [AW:0]        sum_drop;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      rd_inc;
    logic [AW-1:0]      rd_drop;
    logic [FW-1:0]      dcnt_ext;
    logic [FW-1:0]      fill_ext;
    logic [FW-1:0]      ndrop_ext;
    logic [AW-1:0]      ndrop;
    logic [15:0]        ram_q;
    logic signed [16:0] s17;
    logic signed [16:0] lim17;
    logic signed [16:0] clamped;
    logic [15:0]        mag;
    logic [30:0]        mult_w;
    logic [15:0]        q;
    logic [15:0]        decayed;
    logic [15:0]        held_nxt;
    logic               ram_we;

    assign is_write = r_mode == MODE_WRITE;
    assign is_tick  = r_mode == MODE_TICK;
    assign is_drop  = r_mode == MODE_DROP;
    assign full     = r_fill == FILL_MAX;
    assign empty    = r_fill == '0;
    assign out_free = !r_m_valid || i_out_tready;

    assign o_sts.underrun_tick = is_tick && empty;
    assign o_sts.out_free      = out_free;

    // circular index arithmetic, operands always below twice the depth
    assign sum_wr   = {1'b0, r_rd_ptr} + {1'b0, r_fill};
    assign sum_inc  = {1'b0, r_rd_ptr} + (AW + 1)'(1);
    assign sum_drop = {1'b0, r_rd_ptr} + {1'b0, ndrop};
    assign waddr    = (sum_wr   >= DEPTH_V) ? AW'(sum_wr   - DEPTH_V) : sum_wr[AW-1:0];
    assign rd_inc   = (sum_inc  >= DEPTH_V) ? AW'(sum_inc  - DEPTH_V) : sum_inc[AW-1:0];
    assign rd_drop  = (sum_drop >= DEPTH_V) ? AW'(sum_drop - DEPTH_V) : sum_drop[AW-1:0];

    assign dcnt_ext  = FW'(r_dcnt);
    assign fill_ext  = FW'(r_fill);
    assign ndrop_ext = (dcnt_ext < fill_ext) ? dcnt_ext : fill_ext;
    assign ndrop     = ndrop_ext[AW-1:0];

    assign s17     = {ram_q[15], ram_q};
    assign lim17   = signed'({2'b00, r_clamp});
    assign clamped = (s17 > lim17) ? lim17 : ((s17 < -lim17) ? -lim17 : s17);

    assign mag     = r_held[15] ? 16'(-r_held) : r_held;
    assign mult_w  = 31'(mag) * 31'(r_gain);
    assign q       = r_prod[30:15];
    assign decayed = r_neg ? 16'(-q) : q;

    assign held_nxt = empty ? decayed : clamped[15:0];
    assign ram_we   = i_cmd.commit && is_write && !full;

    rfud_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (r_sample),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_in_tdata[15:0];
            r_dcnt   <= i_in_tdata[25:16];
            r_mode   <= i_in_tuser;
            r_last   <= i_in_tlast;
        end
        if (i_cmd.mult) begin
            r_prod <= mult_w;
            r_neg  <= r_held[15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= CLAMP_LIMIT_RST;
            r_gain  <= DECAY_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLAMP_LIMIT: r_clamp <= i_cfg_data;
                CFG_DECAY_GAIN:  r_gain  <= i_cfg_data;
                default:         r_clamp <= r_clamp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_fill    <= '0;
            r_held    <= '0;
            r_brej    <= 1'b0;
            r_bund    <= 1'b0;
            r_ovf     <= '0;
            r_und     <= '0;
            r_frames  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_out_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_m_valid  <= 1'b1;
                r_o_sample <= '0;
                r_o_wacc   <= 1'b0;
                r_o_under  <= 1'b0;
                r_o_drop   <= '0;
                if (is_write) begin
                    if (!full) begin
                        r_fill   <= r_fill + AW'(1);
                        r_o_wacc <= 1'b1;
                    end
                    if (r_last) begin
                        r_brej <= 1'b0;
                        if (r_brej || full) begin
                            r_ovf <= r_ovf + 32'd1;
                        end
                    end else if (full) begin
                        r_brej <= 1'b1;
                    end
                end else if (is_tick) begin
                    r_held     <= held_nxt;
                    r_o_sample <= held_nxt;
                    r_o_under  <= empty;
                    r_frames   <= r_frames + 48'd1;
                    if (!empty) begin
                        r_rd_ptr <= rd_inc;
                        r_fill   <= r_fill - AW'(1);
                    end
                    if (r_last) begin
                        r_bund <= 1'b0;
                        if (r_bund || empty) begin
                            r_und <= r_und + 32'd1;
                        end
                    end else if (empty) begin
                        r_bund <= 1'b1;
                    end
                end else if (is_drop) begin
                    r_rd_ptr <= rd_drop;
                    r_fill   <= r_fill - ndrop;
                    r_o_drop <= ndrop_ext[9:0];
                end
            end
        end
    end

    assign o_out_tvalid = r_m_valid;
    assign o_out_tdata  = {2'b00, r_frames, r_und, r_ovf, fill_ext[9:0], r_o_drop,
                           r_o_under, r_o_wacc, r_o_sample};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond capacity");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_m_valid)
        else $error("commit produced no result");
    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_o_under) |-> (r_fill == '0 && !r_o_wacc))
        else $error("underrun result with samples held");

endmodule

>>> rtl/render_fifo_underrun_decay.sv
// channel  | direction | signals                          | content
// s_axis   | in        | tvalid tready tdata tuser tlast  | one item per transaction
// m_axis   | out       | tvalid tready tdata              | one result per item
// cfg      | in        | i_cfg_we i_cfg_idx i_cfg_data    | 0 clamp_limit, 1 decay_gain
//
// Sample memory reads are registered. Write, drop, pop and unused-mode items
// commit in execute; underrun ticks register the decay product and commit in decay.
// s_axis_tready is high only while the controller is idle.
// A result waits in the output register; m_axis stalls hold the controller
// before its commit, with no state change.
// Synchronous active-low reset; the sample memory is not cleared.
module render_fifo_underrun_decay #(
    parameter int DEPTH = rfud_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] sample_in, [25:16] drop_count, [31:26] zero
    input  logic [rfud_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [rfud_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] out_sample, [16] write_accepted, [17] tick_underrun, [27:18] dropped,
    // [37:28] fill_level, [69:38] overflow_events, [101:70] underrun_events,
    // [149:102] rendered_frames, [151:150] zero
    output logic [rfud_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [rfud_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rfud_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rfud_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    rfud_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_in_tlast   (s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/playout_fifo_checker.sv
module playout_fifo_checker #(
    parameter int DEPTH = rfud_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // [15:0] sample_in, [25:16] drop_count, [31:26] zero
    input  logic [rfud_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] mode
    input  logic [rfud_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                             i_s_tlast,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [15:0] out_sample, [16] write_accepted, [17] tick_underrun, [27:18] dropped,
    // [37:28] fill_level, [69:38] overflow_events, [101:70] underrun_events,
    // [149:102] rendered_frames, [151:150] zero
    input  logic [rfud_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [rfud_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import rfud_pkg::*;

    // packed MSB first, so the layout matches tdata from bit 0 up
    typedef struct packed {
        logic [47:0] rendered_frames;
        logic [31:0] underrun_events;
        logic [31:0] overflow_events;
        logic [9:0]  fill_level;
        logic [9:0]  dropped;
        logic        tick_underrun;
        logic        write_accepted;
        logic [15:0] out_sample;
    } t_playout_result;

    logic [15:0]     sample_mem [DEPTH];
    int              rd_ptr;
    int              fill;
    int              held;
    logic            burst_rejected;
    logic            block_underran;
    logic [31:0]     overflow_cnt;
    logic [31:0]     underrun_cnt;
    logic [47:0]     frame_cnt;
    logic [14:0]     clamp_limit;
    logic [14:0]     decay_gain;
    t_playout_result expected_results [$];

    function automatic t_playout_result predict_playout(input logic [1:0] mode,
                                                        input logic [15:0] sample,
                                                        input logic [9:0] dcount,
                                                        input logic last);
        t_playout_result r;
        int s;
        int lim;
        int mag;
        int n;
        r = '0;
        case (mode)
            MODE_WRITE: begin
                if (fill < DEPTH - 1) begin
                    sample_mem[(rd_ptr + fill) % DEPTH] = sample;
                    fill++;
                    r.write_accepted = 1'b1;
                end else begin
                    burst_rejected = 1'b1;
                end
                if (last) begin
                    if (burst_rejected) overflow_cnt++;
                    burst_rejected = 1'b0;
                end
            end
            MODE_TICK: begin
                if (fill > 0) begin
                    s = int'($signed(sample_mem[rd_ptr]));
                    lim = int'(clamp_limit);
                    if (s > lim) s = lim;
                    if (s < -lim) s = -lim;
                    held = s;
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                end else begin
                    // decay magnitude, truncate toward zero
                    mag = (held < 0) ? -held : held;
                    mag = (mag * int'(decay_gain)) >> 15;
                    held = (held < 0) ? -mag : mag;
                    block_underran = 1'b1;
                    r.tick_underrun = 1'b1;
                end
                r.out_sample = 16'(held);
                if (last) begin
                    if (block_underran) underrun_cnt++;
                    block_underran = 1'b0;
                end
                frame_cnt++;
            end
            MODE_DROP: begin
                n = (int'(dcount) < fill) ? int'(dcount) : fill;
                rd_ptr = (rd_ptr + n) % DEPTH;
                fill -= n;
                r.dropped = 10'(n);
            end
            default: ;
        endcase
        r.fill_level = 10'(fill);
        r.overflow_events = overflow_cnt;
        r.underrun_events = underrun_cnt;
        r.rendered_frames = frame_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_playout_result got;
        t_playout_result want;
        if (!i_rst_n) begin
            rd_ptr = 0;
            fill = 0;
            held = 0;
            burst_rejected = 1'b0;
            block_underran = 1'b0;
            overflow_cnt = '0;
            underrun_cnt = '0;
            frame_cnt = '0;
            clamp_limit = CLAMP_LIMIT_RST;
            decay_gain = DECAY_GAIN_RST;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CLAMP_LIMIT) clamp_limit = i_cfg_data;
                else decay_gain = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_playout(i_s_tuser, i_s_tdata[15:0],
                                                           i_s_tdata[25:16], i_s_tlast));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_playout_result'(i_m_tdata[149:0]);
                if (expected_results.size() == 0) begin
                    $error("result transaction with no item pending");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_sample", longint'($signed(want.out_sample)),
                                longint'($signed(got.out_sample)));
                    check_field("write_accepted", want.write_accepted, got.write_accepted);
                    check_field("tick_underrun", want.tick_underrun, got.tick_underrun);
                    check_field("dropped", want.dropped, got.dropped);
                    check_field("fill_level", want.fill_level, got.fill_level);
                    check_field("overflow_events", want.overflow_events, got.overflow_events);
                    check_field("underrun_events", want.underrun_events, got.underrun_events);
                    check_field("rendered_frames", want.rendered_frames, got.rendered_frames);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/tb_render_fifo_underrun_decay.sv
module tb_render_fifo_underrun_decay;
    import rfud_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_IDLE = 18;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic                   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int cycles = 0;
    bit send_steady;
    bit sink_steady;

    render_fifo_underrun_decay dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    playout_fifo_checker #(.DEPTH(DEPTH_DEF)) playout_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result sink with random stalls
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = sink_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [15:0] sample,
                             input logic [9:0] dcount, input logic last);
        int n;
        n = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, dcount, sample};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold off until every result is back and the controller is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [14:0] clamp, input logic [14:0] gain);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CLAMP_LIMIT;
        i_cfg_data <= clamp;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DECAY_GAIN;
        i_cfg_data <= gain;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // run to full, reject, count the overflow across ticks and drops, then empty
    task automatic fill_past_full();
        int i;
        send_steady = ($urandom_range(0, 1) == 0);
        for (i = 0; i < DEPTH_DEF + 4; i++) send_item(MODE_WRITE, rand_sample(), 10'd0, 1'b0);
        send_item(MODE_TICK, 16'd0, 10'd0, 1'b1);
        send_item(MODE_DROP, 16'd0, 10'd3, 1'b1);
        send_item(MODE_WRITE, rand_sample(), 10'd0, 1'b1);
        for (i = 0; i < 6; i++) send_item(MODE_WRITE, rand_sample(), 10'd0, i == 5);
        for (i = 0; i < 5; i++) send_item(MODE_TICK, 16'($urandom), 10'($urandom), i == 4);
        send_item(MODE_DROP, 16'd0, 10'd1023, 1'b0);
        for (i = 0; i < 4; i++) send_item(MODE_TICK, 16'd0, 10'd0, i == 3);
    endtask

    task automatic run_random(input int n_items);
        int done;
        int len;
        int kind;
        int i;
        logic [1:0] mode;
        done = 0;
        while (done < n_items) begin
            send_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    send_item(MODE_WRITE, rand_sample(), 10'($urandom), i == len - 1);
                done += len;
            end else if (kind < 15) begin
                len = $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                    send_item(MODE_TICK, 16'($urandom), 10'($urandom), i == len - 1);
                done += len;
            end else if (kind < 17) begin
                send_item(MODE_DROP, 16'($urandom),
                          ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8)),
                          1'($urandom));
                done++;
            end else begin
                mode = 2'($urandom);
                send_item(mode, 16'($urandom), 10'($urandom), 1'($urandom));
                if (mode != MODE_UNUSED) done++;
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_CLAMP_LIMIT;
        i_cfg_data    <= '0;
        send_steady = 1'b0;
        sink_steady = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, extremes, clamp both ways, decay of both signs
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b1);
        send_item(MODE_WRITE, 16'h7FFF, 10'd0, 1'b0);
        send_item(MODE_WRITE, 16'h8000, 10'd0, 1'b0);
        send_item(MODE_WRITE, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_WRITE, 16'h1234, 10'd0, 1'b1);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_TICK, 16'hFFFF, 10'h3FF, 1'b0);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b1);
        send_item(MODE_UNUSED, 16'hFFFF, 10'h3FF, 1'b1);
        send_item(MODE_WRITE, 16'd100, 10'd0, 1'b0);
        send_item(MODE_WRITE, -16'sd100, 10'd0, 1'b1);
        send_item(MODE_DROP, 16'h0000, 10'd0, 1'b1);
        send_item(MODE_DROP, 16'hFFFF, 10'h3FF, 1'b1);
        send_item(MODE_DROP, 16'h0000, 10'd5, 1'b0);
        send_item(MODE_WRITE, -16'sd30000, 10'd0, 1'b1);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b1);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b1);
        send_item(MODE_TICK, 16'h0000, 10'd0, 1'b0);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(15'h7FFF, 15'h7FFF);
                1: set_config(15'd0, 15'd0);
                2: set_config(CLAMP_LIMIT_RST, DECAY_GAIN_RST);
                3: set_config(15'd1, 15'($urandom));
                default: set_config(15'($urandom), 15'($urandom));
            endcase
            if (phase == 2 || phase == 4) fill_past_full();
            run_random(135);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

>>> render_fifo_underrun_decay.f
rtl/rfud_pkg.sv
rtl/rfud_ram.sv
rtl/rfud_ctrl.sv
rtl/rfud_dp.sv
rtl/render_fifo_underrun_decay.sv
tb/playout_fifo_checker.sv
tb/tb_render_fifo_underrun_decay.sv
